// File: sv/sha_pkg.sv
// Shared types, round constants and sigma functions of the SHA-256 stream hasher.
`default_nettype none

package sha_pkg;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       has_byte;
    logic       end_of_message;
  } in_word_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_word_t;

  // Commands from the sequencer to the round unit.
  typedef struct packed {
    logic start;
    logic reinit;
  } rnd_ctrl_t;

  // Status of the round unit.
  typedef struct packed {
    logic busy;
    logic step;
    logic done;
  } rnd_stat_t;

  localparam logic [255:0] H_INIT = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input logic [4:0] n);
    rotr = (x >> n) | (x << (6'd32 - {1'b0, n}));
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    big_sigma0 = rotr(x, 5'd2) ^ rotr(x, 5'd13) ^ rotr(x, 5'd22);
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    big_sigma1 = rotr(x, 5'd6) ^ rotr(x, 5'd11) ^ rotr(x, 5'd25);
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    small_sigma0 = rotr(x, 5'd7) ^ rotr(x, 5'd18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    small_sigma1 = rotr(x, 5'd17) ^ rotr(x, 5'd19) ^ (x >> 10);
  endfunction

endpackage

`default_nettype wire

// File: sv/sha256_stream_hasher.sv
// Top level of the SHA-256 stream hasher: sequencer, padding and digest output.
// A byte that does not complete a block is taken without stalling; a byte that completes a
// block keeps the input closed while the round unit runs its rounds and the final add.
// An end-of-message word pads one byte per cycle to the end of the block, compresses (twice
// when the length spills), then emits eight digest words, one a cycle while out_ready_i is
// high. The round unit is shared. Reset clears the control state and loads the initial hash.
`default_nettype none

module sha256_stream_hasher (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire sha_pkg::in_word_t  in_word_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output sha_pkg::out_word_t      out_word_o
);

  // Sequencer states. IDLE takes input words, PAD feeds padding bytes into the
  // block buffer, COMP waits for the round unit, DONE hands the digest over to
  // the output buffer once that buffer has drained.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PAD  = 2'd1;
  localparam logic [1:0] ST_COMP = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]   state_q, state_d;
  logic [5:0]   fill_q, fill_d;
  logic [60:0]  total_q, total_d;
  logic         pad_pend_q, pad_pend_d;   // message end seen, padding still to run
  logic         pad_first_q, pad_first_d; // next padding byte is the 0x80 marker
  logic         spill_q, spill_d;         // current block is the spill block
  logic         final_q, final_d;         // running compression is the last one

  logic         in_acc;
  logic         out_acc;
  logic         shift_en;
  logic [7:0]   shift_byte;
  logic         full_evt;
  logic         marker_late;
  logic [63:0]  len_bits;
  logic [2:0]   len_sel;
  logic [7:0]   len_byte;
  logic [7:0]   pad_byte;

  logic [255:0] obuf_q;
  logic [3:0]   ocnt_q;
  logic [2:0]   oidx_q;
  logic         obuf_load;

  sha_pkg::rnd_ctrl_t rnd_ctrl;
  sha_pkg::rnd_stat_t rnd_stat;
  logic [31:0]        w;
  logic [255:0]       hash;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i & in_ready_o;
  assign out_valid_o = (ocnt_q != 4'd0);
  assign out_acc     = out_valid_o & out_ready_i;

  assign out_word_o.digest_word = obuf_q[255:224];
  assign out_word_o.word_index  = oidx_q;
  assign out_word_o.last_word   = (oidx_q == 3'd7);

  // The length field is the byte count times eight, stored big-endian in the
  // last eight bytes of the final block.
  assign len_bits = {total_q, 3'b000};
  assign len_sel  = ~fill_q[2:0];
  assign len_byte = len_bits[{len_sel, 3'b000} +: 8];

  // The 0x80 marker landing at or beyond the length position forces an extra block.
  assign marker_late = pad_first_q && (fill_q >= sha_pkg::LEN_POS);

  always_comb begin
    if (pad_first_q) begin
      pad_byte = sha_pkg::PAD_BYTE;
    end else if ((fill_q >= sha_pkg::LEN_POS) && !spill_q) begin
      pad_byte = len_byte;
    end else begin
      pad_byte = 8'h00;
    end
  end

  assign shift_en   = (in_acc && in_word_i.has_byte) || (state_q == ST_PAD);
  assign shift_byte = (state_q == ST_PAD) ? pad_byte : in_word_i.msg_byte;
  assign full_evt   = shift_en && (fill_q == 6'd63);
  assign obuf_load  = (state_q == ST_DONE) && (ocnt_q == 4'd0);

  assign rnd_ctrl.start  = full_evt;
  assign rnd_ctrl.reinit = obuf_load;

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    total_d     = total_q;
    pad_pend_d  = pad_pend_q;
    pad_first_d = pad_first_q;
    spill_d     = spill_q;
    final_d     = final_q;

    if (shift_en) begin
      fill_d = fill_q + 6'd1;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_word_i.has_byte) begin
            total_d = total_q + 61'd1;
          end
          if (in_word_i.end_of_message) begin
            pad_pend_d  = 1'b1;
            pad_first_d = 1'b1;
          end
          if (full_evt) begin
            final_d = 1'b0;
            state_d = ST_COMP;
          end else if (in_word_i.end_of_message) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        pad_first_d = 1'b0;
        if (marker_late) begin
          spill_d = 1'b1;
        end
        if (full_evt) begin
          spill_d = 1'b0;
          final_d = !(spill_q || marker_late);
          state_d = ST_COMP;
        end
      end
      ST_COMP: begin
        if (rnd_stat.done) begin
          if (final_q) begin
            state_d = ST_DONE;
          end else if (pad_pend_q) begin
            state_d = ST_PAD;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_DONE: begin
        if (obuf_load) begin
          total_d    = '0;
          pad_pend_d = 1'b0;
          final_d    = 1'b0;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      total_q     <= '0;
      pad_pend_q  <= 1'b0;
      pad_first_q <= 1'b0;
      spill_q     <= 1'b0;
      final_q     <= 1'b0;
      ocnt_q      <= '0;
      oidx_q      <= '0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      total_q     <= total_d;
      pad_pend_q  <= pad_pend_d;
      pad_first_q <= pad_first_d;
      spill_q     <= spill_d;
      final_q     <= final_d;
      if (obuf_load) begin
        ocnt_q <= 4'd8;
        oidx_q <= '0;
      end else if (out_acc) begin
        ocnt_q <= ocnt_q - 4'd1;
        oidx_q <= oidx_q + 3'd1;
      end
    end
  end

  // The digest is copied out so the next message can start while it drains.
  always_ff @(posedge clk_i) begin
    if (obuf_load) begin
      obuf_q <= hash;
    end else if (out_acc) begin
      obuf_q <= {obuf_q[223:0], 32'h0};
    end
  end

  sha_msg_sched u_sched (
    .clk_i     (clk_i),
    .byte_en_i (shift_en),
    .byte_i    (shift_byte),
    .step_i    (rnd_stat.step),
    .w_o       (w)
  );

  sha_round u_round (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (rnd_ctrl),
    .w_i    (w),
    .stat_o (rnd_stat),
    .hash_o (hash)
  );

  // A new compression never starts while the round unit is still working.
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rnd_ctrl.start |-> !rnd_stat.busy)
    else $error("round unit started while busy");

  // The digest is handed over only at a block boundary.
  a_done_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE |-> fill_q == 6'd0)
    else $error("digest ready with a partial block");

  // After the last digest word leaves, the output side goes quiet.
  a_last_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && out_word_o.last_word |=> !out_valid_o)
    else $error("output still valid after the last digest word");

endmodule

`default_nettype wire

// File: sv/sha_msg_sched.sv
// Block buffer and rolling message schedule of the SHA-256 stream hasher.
`default_nettype none

module sha_msg_sched (
  input  wire logic        clk_i,
  input  wire logic        byte_en_i,
  input  wire logic [7:0]  byte_i,
  input  wire logic        step_i,
  output logic      [31:0] w_o
);

  // Word 0 of the window sits in the top bits.
  logic [511:0] blk_q;
  logic [511:0] blk_d;
  logic [31:0]  w_new;

  function automatic logic [31:0] win(input logic [511:0] b, input int unsigned i);
    win = b[511 - 32 * i -: 32];
  endfunction

  assign w_o   = win(blk_q, 0);
  assign w_new = win(blk_q, 0) + sha_pkg::small_sigma0(win(blk_q, 1))
               + win(blk_q, 9) + sha_pkg::small_sigma1(win(blk_q, 14));

  always_comb begin
    blk_d = blk_q;
    if (byte_en_i) begin
      blk_d = {blk_q[503:0], byte_i};
    end else if (step_i) begin
      blk_d = {blk_q[479:0], w_new};
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q <= blk_d;
  end

endmodule

`default_nettype wire

// File: sv/sha_round.sv
// SHA-256 round unit: hash state, working variables and one round per cycle.
`default_nettype none

module sha_round (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire sha_pkg::rnd_ctrl_t  ctrl_i,
  input  wire logic         [31:0] w_i,
  output sha_pkg::rnd_stat_t       stat_o,
  output logic             [255:0] hash_o
);

  logic [31:0] h_q [8];
  logic [31:0] a_q, b_q, c_q, d_q, e_q, f_q, g_q, hh_q;
  logic [5:0]  cnt_q;
  logic        act_q;
  logic        add_q;
  logic [31:0] t1, t2;

  assign t1 = hh_q + sha_pkg::big_sigma1(e_q) + ((e_q & f_q) ^ (~e_q & g_q))
            + sha_pkg::ROUND_K[cnt_q] + w_i;
  assign t2 = sha_pkg::big_sigma0(a_q) + ((a_q & b_q) ^ (a_q & c_q) ^ (b_q & c_q));

  assign stat_o.busy = act_q | add_q;
  assign stat_o.step = act_q;
  assign stat_o.done = add_q;

  assign hash_o = {h_q[0], h_q[1], h_q[2], h_q[3], h_q[4], h_q[5], h_q[6], h_q[7]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      add_q <= 1'b0;
      cnt_q <= '0;
      for (int i = 0; i < 8; i++) begin
        h_q[i] <= sha_pkg::H_INIT[255 - 32 * i -: 32];
      end
    end else begin
      // The final add follows the cycle of the last round.
      add_q <= act_q && !ctrl_i.start && (cnt_q == 6'd63);
      if (ctrl_i.start) begin
        act_q <= 1'b1;
        cnt_q <= '0;
      end else if (act_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          act_q <= 1'b0;
        end
      end
      if (add_q) begin
        h_q[0] <= h_q[0] + a_q;
        h_q[1] <= h_q[1] + b_q;
        h_q[2] <= h_q[2] + c_q;
        h_q[3] <= h_q[3] + d_q;
        h_q[4] <= h_q[4] + e_q;
        h_q[5] <= h_q[5] + f_q;
        h_q[6] <= h_q[6] + g_q;
        h_q[7] <= h_q[7] + hh_q;
      end else if (ctrl_i.reinit) begin
        for (int i = 0; i < 8; i++) begin
          h_q[i] <= sha_pkg::H_INIT[255 - 32 * i -: 32];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      a_q  <= h_q[0];
      b_q  <= h_q[1];
      c_q  <= h_q[2];
      d_q  <= h_q[3];
      e_q  <= h_q[4];
      f_q  <= h_q[5];
      g_q  <= h_q[6];
      hh_q <= h_q[7];
    end else if (act_q) begin
      hh_q <= g_q;
      g_q  <= f_q;
      f_q  <= e_q;
      e_q  <= d_q + t1;
      d_q  <= c_q;
      c_q  <= b_q;
      b_q  <= a_q;
      a_q  <= t1 + t2;
    end
  end

endmodule

`default_nettype wire
